@@ rtl/idiv_pkg.sv @@
// shared types and constants of the signed/unsigned integer divider
// no dependencies; used by every other file of the block
package idiv_pkg;

   localparam int NARROW_BITS = 32;
   localparam int WIDE_BITS   = 64;
   localparam int CNT_W       = $clog2(WIDE_BITS);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] CMD_UNSIGNED_32 = 2'd0;
   localparam logic [1:0] CMD_SIGNED_32   = 2'd1;
   localparam logic [1:0] CMD_UNSIGNED_64 = 2'd2;
   localparam logic [1:0] CMD_SIGNED_64   = 2'd3;

   // one classified division job as it waits between front and back
   typedef struct packed {
      logic                 wide;
      logic                 zero;
      logic                 neg_q;
      logic                 neg_r;
      logic [WIDE_BITS-1:0] mag_a;
      logic [WIDE_BITS-1:0] mag_b;
   } job_type;

endpackage

@@ rtl/idiv_if.sv @@
// valid/ready channel interfaces of the divider: request and response
// depends on idiv_pkg for the operand widths
interface idiv_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     cmd;
   logic [idiv_pkg::WIDE_BITS-1:0] dividend;
   logic [idiv_pkg::WIDE_BITS-1:0] divisor;

   modport source (output valid, cmd, dividend, divisor, input ready);
   modport sink   (input valid, cmd, dividend, divisor, output ready);
endinterface

interface idiv_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [idiv_pkg::WIDE_BITS-1:0] quotient;
   logic [idiv_pkg::WIDE_BITS-1:0] remainder;

   modport source (output valid, quotient, remainder, input ready);
   modport sink   (input valid, quotient, remainder, output ready);
endinterface

@@ rtl/idiv_front.sv @@
// front end: accepts requests, masks operands, takes magnitudes, flags zero cases
// depends on idiv_pkg and idiv_if
module idiv_front (
   idiv_req_if.sink           req,
   input  logic               queue_full,
   output logic               push,
   output idiv_pkg::job_type  job
);

   localparam int W = idiv_pkg::WIDE_BITS;
   localparam int N = idiv_pkg::NARROW_BITS;

   logic         wide;
   logic         is_signed;
   logic [W-1:0] mask;
   logic [W-1:0] a;
   logic [W-1:0] b;
   logic         a_neg;
   logic         b_neg;

   always_comb begin
      unique case (req.cmd)
         idiv_pkg::CMD_UNSIGNED_32: begin
            wide = 1'b0;
            is_signed = 1'b0;
         end
         idiv_pkg::CMD_SIGNED_32: begin
            wide = 1'b0;
            is_signed = 1'b1;
         end
         idiv_pkg::CMD_UNSIGNED_64: begin
            wide = 1'b1;
            is_signed = 1'b0;
         end
         default: begin
            wide = 1'b1;
            is_signed = 1'b1;
         end
      endcase
   end

   assign mask  = wide ? {W{1'b1}} : {{(W-N){1'b0}}, {N{1'b1}}};
   assign a     = req.dividend & mask;
   assign b     = req.divisor & mask;
   assign a_neg = is_signed && (wide ? a[W-1] : a[N-1]);
   assign b_neg = is_signed && (wide ? b[W-1] : b[N-1]);

   always_comb begin
      job.wide  = wide;
      job.zero  = (a == '0) || (b == '0);
      job.neg_q = a_neg ^ b_neg;
      job.neg_r = a_neg;
      job.mag_a = a_neg ? ((~a + W'(1)) & mask) : a;
      job.mag_b = b_neg ? ((~b + W'(1)) & mask) : b;
   end

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

endmodule

@@ rtl/idiv_queue.sv @@
// short register queue of classified jobs between front and back
// depends on idiv_pkg for the job type
module idiv_queue #(
   parameter int DEPTH = idiv_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  idiv_pkg::job_type push_job,
   input  logic              pop,
   output idiv_pkg::job_type head_job,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   idiv_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slot_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[tail_ff] <= push_job;
      end
   end

endmodule

@@ rtl/idiv_back.sv @@
// back end: restoring shift-subtract core, one quotient bit a cycle, sign fix-up
// and the response output register; depends on idiv_pkg and idiv_if
module idiv_back (
   input  logic              clock,
   input  logic              reset,
   input  idiv_pkg::job_type head_job,
   input  logic              queue_empty,
   output logic              pop,
   idiv_rsp_if.source        rsp
);

   localparam int W     = idiv_pkg::WIDE_BITS;
   localparam int N     = idiv_pkg::NARROW_BITS;
   localparam int CNT_W = idiv_pkg::CNT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIX  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     quo_ff, quo_in;    // dividend bits shift out, quotient bits shift in
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     div_ff, div_in;
   logic             wide_ff, wide_in;
   logic             neg_q_ff, neg_q_in;
   logic             neg_r_ff, neg_r_in;
   logic             valid_ff, valid_in;
   logic [W-1:0]     q_out_ff, r_out_ff;
   logic             load_out;

   logic [W:0]       shifted;
   logic [W:0]       diff;
   logic [W-1:0]     mask;
   logic [W-1:0]     q_fixed;
   logic [W-1:0]     r_fixed;

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign mask    = wide_ff ? {W{1'b1}} : {{(W-N){1'b0}}, {N{1'b1}}};
   assign q_fixed = (neg_q_ff ? (~quo_ff + W'(1)) : quo_ff) & mask;
   assign r_fixed = (neg_r_ff ? (~rem_ff + W'(1)) : rem_ff) & mask;

   assign pop      = (state_ff == ST_IDLE) && !queue_empty;
   assign load_out = (state_ff == ST_FIX) && (!valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      wide_in  = wide_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      valid_in = valid_ff;
      if (valid_ff && rsp.ready) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               wide_in  = head_job.wide;
               neg_q_in = head_job.neg_q;
               neg_r_in = head_job.neg_r;
               div_in   = head_job.mag_b;
               rem_in   = '0;
               cnt_in   = head_job.wide ? CNT_W'(W - 1) : CNT_W'(N - 1);
               if (head_job.zero) begin
                  quo_in   = '0;
                  state_in = ST_FIX;
               end else begin
                  // narrow operands sit in the top half so the msb shifts out first
                  quo_in   = head_job.wide ? head_job.mag_a
                                           : {head_job.mag_a[N-1:0], {(W-N){1'b0}}};
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (!diff[W]) begin
               rem_in = diff[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = shifted[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (load_out) begin
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      wide_ff  <= wide_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      if (load_out) begin
         q_out_ff <= q_fixed;
         r_out_ff <= r_fixed;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.quotient  = q_out_ff;
   assign rsp.remainder = r_out_ff;

endmodule

@@ rtl/integer_divider_signed_unsigned.sv @@
// top level of the signed/unsigned 32/64-bit integer divider
// depends on idiv_pkg, idiv_if, idiv_front, idiv_queue and idiv_back
//
// channel    dir  payload                         handshake
// req_chan   in   cmd[1:0] dividend[63:0] divisor[63:0]   valid/ready
// rsp_chan   out  quotient[63:0] remainder[63:0]          valid/ready
//
// a request enters the job queue in the cycle it is accepted; the back end takes
// one job at a time from the queue, runs the shift-subtract loop one quotient bit
// per cycle (64 bits wide, 32 narrow), then does the sign fix-up; a job with a
// zero operand skips the loop. the queue takes new requests while the back end
// works on a job. reset is synchronous and empties queue and output register.
// a stalled response holds the back end in fix-up; the front keeps filling the queue.
module integer_divider_signed_unsigned #(
   parameter int QUEUE_DEPTH = idiv_pkg::QUEUE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   idiv_req_if.sink   req_chan,
   idiv_rsp_if.source rsp_chan
);

   idiv_pkg::job_type push_job;
   idiv_pkg::job_type head_job;
   logic              push;
   logic              pop;
   logic              full;
   logic              empty;

   idiv_front u_front (
      .req        (req_chan),
      .queue_full (full),
      .push       (push),
      .job        (push_job)
   );

   idiv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (full),
      .empty    (empty)
   );

   idiv_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .queue_empty (empty),
      .pop         (pop),
      .rsp         (rsp_chan)
   );

endmodule
